/* rtl/status_led_pattern_sequencer_unit_defines.svh */
// assertion macros for the status led pattern sequencer
`ifndef STATUS_LED_PATTERN_SEQUENCER_UNIT_DEFINES_SVH
`define STATUS_LED_PATTERN_SEQUENCER_UNIT_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication, disabled in reset
`define SLPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("slps assertion failed");

// next-cycle implication, disabled in reset
`define SLPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("slps assertion failed");

`else

`define SLPS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SLPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/slps_pkg.sv */
// types, codes and blink timing tables for the status led pattern sequencer
package slps_pkg;

    localparam int TIME_BITS = 32;

    localparam int NOW_W    = 32;
    localparam int MODE_W   = 3;
    localparam int COUNT_W  = 8;
    localparam int PULSE_W  = 16;
    localparam int FUNC_W   = 2;
    localparam int CFG_IDX_W = 1;

    // input word layout, lowest field first
    localparam int IN_NOW_LO   = 0;
    localparam int IN_MODE_LO  = IN_NOW_LO + NOW_W;
    localparam int IN_COUNT_LO = IN_MODE_LO + MODE_W;
    localparam int IN_ON_LO    = IN_COUNT_LO + COUNT_W;
    localparam int IN_OFF_LO   = IN_ON_LO + PULSE_W;
    localparam int IN_USED_W   = IN_OFF_LO + PULSE_W;
    localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;

    // result word layout
    localparam int OUT_USED_W = 1 + 1 + MODE_W + 1;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_UPDATE   = 2'd0,
        FUNC_SET_MODE = 2'd1,
        FUNC_FLASH    = 2'd2,
        FUNC_RESERVED = 2'd3
    } t_func;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF        = 3'd0,
        MODE_SLOW       = 3'd1,
        MODE_COUNTDOWN  = 3'd2,
        MODE_SOLID      = 3'd3,
        MODE_FINISH     = 3'd4,
        MODE_ERROR      = 3'd5,
        MODE_NOSIGNAL   = 3'd6,
        MODE_ACKTIMEOUT = 3'd7
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLED      = 1'b0,
        CFG_ACTIVE_LEVEL = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic                burst_busy;
        logic [MODE_W-1:0]   current_mode;
        logic                pin_level;
        logic                lit;
    } t_result;

    function automatic logic [PULSE_W-1:0] f_on_time(input t_mode mode);
        logic [PULSE_W-1:0] t;
        unique case (mode)
            MODE_OFF:        t = PULSE_W'(0);
            MODE_SLOW:       t = PULSE_W'(120);
            MODE_COUNTDOWN:  t = PULSE_W'(100);
            MODE_SOLID:      t = PULSE_W'(0);
            MODE_FINISH:     t = PULSE_W'(100);
            MODE_ERROR:      t = PULSE_W'(120);
            MODE_NOSIGNAL:   t = PULSE_W'(80);
            MODE_ACKTIMEOUT: t = PULSE_W'(120);
            default:         t = PULSE_W'(0);
        endcase
        return t;
    endfunction

    function automatic logic [PULSE_W-1:0] f_off_time(input t_mode mode);
        logic [PULSE_W-1:0] t;
        unique case (mode)
            MODE_OFF:        t = PULSE_W'(0);
            MODE_SLOW:       t = PULSE_W'(1880);
            MODE_COUNTDOWN:  t = PULSE_W'(100);
            MODE_SOLID:      t = PULSE_W'(0);
            MODE_FINISH:     t = PULSE_W'(120);
            MODE_ERROR:      t = PULSE_W'(120);
            MODE_NOSIGNAL:   t = PULSE_W'(920);
            MODE_ACKTIMEOUT: t = PULSE_W'(120);
            default:         t = PULSE_W'(0);
        endcase
        return t;
    endfunction

endpackage

/* rtl/status_led_pattern_sequencer_unit.sv */
// status led pattern sequencer: mode blink timing, flash bursts, output skid buffer
//
//  channel   | direction | handshake                      | payload
//  ----------+-----------+--------------------------------+-------------------------------
//  s_axis    | in        | i_s_axis_tvalid/o_s_axis_tready| tuser func, tdata timing fields
//  m_axis    | out       | o_m_axis_tvalid/i_m_axis_tready| tdata led state and mode
//  cfg       | in        | i_cfg_valid/o_cfg_ready        | i_cfg_index, i_cfg_data
//
//  one word in per cycle while the skid entry is free; its result is registered in the result buffer when taken
//  the state update is one time subtract and compare plus selection, done at input accept
//  a two-entry result buffer keeps the input open while one result waits downstream
//  input stalls only when both result entries are full; cfg is always ready
//  synchronous active-low reset clears state to off mode, dark, no burst
`include "status_led_pattern_sequencer_unit_defines.svh"

module status_led_pattern_sequencer_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // stream in
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // now_ms[31:0], new_mode[34:32], pulse_count[42:35], pulse_on_ms[58:43],
    // pulse_off_ms[74:59], zero pad to 80 bits
    input  logic [slps_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // func[1:0]
    input  logic [slps_pkg::FUNC_W-1:0]        i_s_axis_tuser,
    // stream out
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // lit[0], pin_level[1], current_mode[4:2], burst_busy[5], zero pad to 8 bits
    output logic [slps_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // config writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [slps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic                               i_cfg_data
);

    localparam int TB = slps_pkg::TIME_BITS;

    // config
    logic r_enabled;
    logic r_active_level;

    // led state
    slps_pkg::t_mode                    r_mode, n_mode;
    logic                               r_lit, n_lit;
    logic [TB-1:0]                      r_last, n_last;
    logic                               r_burst_active, n_burst_active;
    logic                               r_burst_on_phase, n_burst_on_phase;
    logic [slps_pkg::COUNT_W-1:0]       r_burst_left, n_burst_left;
    logic [slps_pkg::PULSE_W-1:0]       r_burst_on_time, n_burst_on_time;
    logic [slps_pkg::PULSE_W-1:0]       r_burst_off_time, n_burst_off_time;

    // result buffer
    logic                  r_out_valid;
    logic                  r_skid_valid;
    slps_pkg::t_result     r_out_data;
    slps_pkg::t_result     r_skid_data;

    logic                               w_in_acc;
    logic                               w_out_take;
    slps_pkg::t_func                    w_func;
    logic [TB-1:0]                      w_now;
    slps_pkg::t_mode                    w_new_mode;
    logic [slps_pkg::COUNT_W-1:0]       w_count;
    logic [slps_pkg::PULSE_W-1:0]       w_pon;
    logic [slps_pkg::PULSE_W-1:0]       w_poff;
    logic [TB-1:0]                      w_delta;
    logic [slps_pkg::PULSE_W-1:0]       w_burst_iv;
    logic [slps_pkg::PULSE_W-1:0]       w_mode_iv;
    logic                               w_burst_due;
    logic                               w_mode_due;
    slps_pkg::t_result                  w_result;

    assign o_s_axis_tready = !r_skid_valid;
    assign o_cfg_ready     = 1'b1;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_take      = r_out_valid && i_m_axis_tready;

    assign w_func     = slps_pkg::t_func'(i_s_axis_tuser);
    assign w_now      = TB'(i_s_axis_tdata[slps_pkg::IN_NOW_LO +: slps_pkg::NOW_W]);
    assign w_new_mode = slps_pkg::t_mode'(i_s_axis_tdata[slps_pkg::IN_MODE_LO +: slps_pkg::MODE_W]);
    assign w_count    = i_s_axis_tdata[slps_pkg::IN_COUNT_LO +: slps_pkg::COUNT_W];
    assign w_pon      = i_s_axis_tdata[slps_pkg::IN_ON_LO +: slps_pkg::PULSE_W];
    assign w_poff     = i_s_axis_tdata[slps_pkg::IN_OFF_LO +: slps_pkg::PULSE_W];

    // wrapping elapsed time since the last toggle, mode change or flash start
    assign w_delta     = w_now - r_last;
    assign w_burst_iv  = r_burst_on_phase ? r_burst_on_time : r_burst_off_time;
    assign w_mode_iv   = r_lit ? slps_pkg::f_on_time(r_mode) : slps_pkg::f_off_time(r_mode);
    assign w_burst_due = w_delta >= TB'(w_burst_iv);
    assign w_mode_due  = w_delta >= TB'(w_mode_iv);

    always_comb begin
        n_mode           = r_mode;
        n_lit            = r_lit;
        n_last           = r_last;
        n_burst_active   = r_burst_active;
        n_burst_on_phase = r_burst_on_phase;
        n_burst_left     = r_burst_left;
        n_burst_on_time  = r_burst_on_time;
        n_burst_off_time = r_burst_off_time;
        unique case (w_func)
            slps_pkg::FUNC_UPDATE: begin
                if (r_enabled) begin
                    if (r_burst_active) begin
                        // burst runs ahead of the mode pattern
                        if (w_burst_due) begin
                            if (r_burst_on_phase) begin
                                n_burst_on_phase = 1'b0;
                                n_lit            = 1'b0;
                            end else if (r_burst_left != '0) begin
                                n_burst_left = r_burst_left - 1'b1;
                                if (r_burst_left == slps_pkg::COUNT_W'(1)) begin
                                    n_burst_active = 1'b0;
                                    n_lit          = 1'b0;
                                end else begin
                                    n_burst_on_phase = 1'b1;
                                    n_lit            = 1'b1;
                                end
                            end
                            n_last = w_now;
                        end
                    end else if (r_mode == slps_pkg::MODE_OFF) begin
                        n_lit = 1'b0;
                    end else if (r_mode == slps_pkg::MODE_SOLID) begin
                        n_lit = 1'b1;
                    end else if (w_mode_due) begin
                        n_lit  = !r_lit;
                        n_last = w_now;
                    end
                end
            end
            slps_pkg::FUNC_SET_MODE: begin
                if (r_mode != w_new_mode) begin
                    n_mode = w_new_mode;
                    n_last = w_now;
                end
            end
            slps_pkg::FUNC_FLASH: begin
                if (r_enabled && (w_count != '0)) begin
                    n_mode           = slps_pkg::MODE_FINISH;
                    n_burst_active   = 1'b1;
                    n_burst_on_phase = 1'b1;
                    n_burst_left     = w_count;
                    n_burst_on_time  = w_pon;
                    n_burst_off_time = w_poff;
                    n_last           = w_now;
                    n_lit            = 1'b1;
                end
            end
            slps_pkg::FUNC_RESERVED: begin
                // state reported unchanged
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        w_result.lit          = n_lit;
        w_result.pin_level    = n_lit ? r_active_level : !r_active_level;
        w_result.current_mode = n_mode;
        w_result.burst_busy   = n_burst_active;
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled      <= 1'b1;
            r_active_level <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (slps_pkg::t_cfg_idx'(i_cfg_index))
                slps_pkg::CFG_ENABLED:      r_enabled      <= i_cfg_data;
                slps_pkg::CFG_ACTIVE_LEVEL: r_active_level <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // led state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode           <= slps_pkg::MODE_OFF;
            r_lit            <= 1'b0;
            r_last           <= '0;
            r_burst_active   <= 1'b0;
            r_burst_on_phase <= 1'b0;
            r_burst_left     <= '0;
            r_burst_on_time  <= '0;
            r_burst_off_time <= '0;
        end else if (w_in_acc) begin
            r_mode           <= n_mode;
            r_lit            <= n_lit;
            r_last           <= n_last;
            r_burst_active   <= n_burst_active;
            r_burst_on_phase <= n_burst_on_phase;
            r_burst_left     <= n_burst_left;
            r_burst_on_time  <= n_burst_on_time;
            r_burst_off_time <= n_burst_off_time;
        end
    end

    // result buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || w_out_take) begin
                r_out_valid  <= r_skid_valid || w_in_acc;
                r_skid_valid <= 1'b0;
            end else if (w_in_acc) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // result buffer payload
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_out_take) begin
            r_out_data <= r_skid_valid ? r_skid_data : w_result;
        end
        if (w_in_acc) begin
            r_skid_data <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = slps_pkg::OUT_DATA_W'(r_out_data);

    `SLPS_ASSERT_NOW(a_burst_left_nonzero, i_clk, i_rst_n, r_burst_active, r_burst_left != '0)
    `SLPS_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `SLPS_ASSERT_NEXT(a_accept_fills_out, i_clk, i_rst_n, w_in_acc && !r_out_valid, r_out_valid)
    `SLPS_ASSERT_NEXT(a_disabled_frozen, i_clk, i_rst_n, w_in_acc && !r_enabled && (w_func == slps_pkg::FUNC_UPDATE), $stable(r_lit) && $stable(r_burst_active) && $stable(r_last))

endmodule
